>>> rtl/ssa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared types and constants of the segregated span page allocator.
// ----------------------------------------------------------------------------
package ssa_pkg;

  localparam int BUCKETS      = 128;
  localparam int SPAN_ENTRIES = 1024;

  localparam int PAGE_W   = 36;
  localparam int K_W      = 7;
  localparam int LIMIT_W  = 16;
  localparam int BKT_W    = $clog2(BUCKETS);
  localparam int DSC_W    = $clog2(SPAN_ENTRIES);
  localparam int CNT_W    = DSC_W + 1;
  localparam int SCAN_W   = 8;
  localparam int NGRP     = (BUCKETS + SCAN_W - 1) / SCAN_W;
  localparam int GRP_W    = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_PAGE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_LIMIT = 1'd1;

  typedef enum logic [1:0] {
    ST_GRANT    = 2'd0,
    ST_EXHAUST  = 2'd1,
    ST_FULL     = 2'd2,
    ST_BADSIZE  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    B_IDLE, B_SCAN, B_REFILL, B_SPARE, B_HEAD, B_SPAN, B_PUSH, B_DONE
  } bstate_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic           valid;
    logic           bad;
    logic [K_W-1:0] k;
  } qitem_t;

endpackage

>>> rtl/ssa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_req_if / ssa_resp_if
// Valid/ready channels for allocation requests and responses.
// ----------------------------------------------------------------------------
interface ssa_req_if;
  import ssa_pkg::*;
  logic           valid;
  logic           ready;
  logic [K_W-1:0] pages_requested;
  modport source (output valid, output pages_requested, input ready);
  modport sink   (input valid, input pages_requested, output ready);
endinterface

interface ssa_resp_if;
  import ssa_pkg::*;
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] span_start_page;
  logic [K_W-1:0]    span_pages;
  logic [1:0]        status;
  modport source (output valid, output span_start_page, output span_pages,
                  output status, input ready);
  modport sink   (input valid, input span_start_page, input span_pages,
                  input status, output ready);
endinterface

>>> rtl/ssa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_front
// Accepts requests, flags bad sizes and queues them for the back end.
// ----------------------------------------------------------------------------
module ssa_front import ssa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  ssa_req_if.sink     in_req,
  output qitem_t      q_head,
  input  logic        q_pop
);

  qitem_t     q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  qitem_t     item;

  assign in_req.ready = (cnt_r != 2'd2);
  assign push         = in_req.valid && in_req.ready;

  // Classify the incoming transaction.
  always_comb begin
    item.valid = 1'b1;
    item.k     = in_req.pages_requested;
    item.bad   = (in_req.pages_requested == '0) ||
                 (32'(in_req.pages_requested) >= BUCKETS);
  end

  always_comb begin
    q_head       = q_r[rp_r];
    q_head.valid = (cnt_r != 2'd0);
  end

  // Two-entry queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= item;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

>>> rtl/ssa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_back
// Executes requests against the bucket lists and descriptor memories.
// ----------------------------------------------------------------------------
module ssa_back import ssa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  qitem_t              q_head,
  output logic                q_pop,
  input  logic [PAGE_W-1:0]   base_page,
  input  logic [LIMIT_W-1:0]  region_limit,
  ssa_resp_if.source          out_rsp
);

  localparam int PADW = NGRP * SCAN_W;

  // Memories.
  logic [DSC_W-1:0]  head_mem [BUCKETS];
  logic [PAGE_W-1:0] fp_mem   [SPAN_ENTRIES];
  logic [DSC_W-1:0]  link_mem [SPAN_ENTRIES];
  logic [DSC_W-1:0]  head_q, link_q;
  logic [PAGE_W-1:0] fp_q;

  logic [BUCKETS-1:0] ne_r;
  bstate_t            st_r, st_nxt;
  logic [K_W-1:0]     kin_r;
  logic [BKT_W-1:0]   bkt_r;
  logic [DSC_W-1:0]   d_r;
  logic [GRP_W-1:0]   grp_r;
  logic [DSC_W-1:0]   spare_head_r;
  logic [CNT_W-1:0]   spare_cnt_r, fresh_cnt_r;
  logic [LIMIT_W-1:0] regions_r;
  logic [PAGE_W-1:0]  start_r;
  status_t            status_r;
  logic               out_valid_r;
  logic [PAGE_W-1:0]  out_start_r;
  logic [K_W-1:0]     out_pages_r;
  logic [1:0]         out_status_r;

  // Combinational controls.
  logic [BKT_W-1:0]  k_b, b2, hit_idx;
  logic [GRP_W-1:0]  kgrp;
  logic [PADW-1:0]   ne_pad;
  logic [SCAN_W-1:0] win, mask;
  logic [2:0]        pe;
  logic              hit;
  logic [BKT_W-1:0]  head_ra, head_wa;
  logic [DSC_W-1:0]  head_wd, span_ra, link_wa, link_wd, fp_wa;
  logic              head_we, link_we, fp_we;
  logic [PAGE_W-1:0] fp_wd, region_page;
  logic              ne_set, ne_clr;
  logic [BKT_W-1:0]  ne_set_idx, ne_clr_idx;
  logic              refill, load_out;
  logic [DSC_W-1:0]  refill_d;

  assign k_b    = BKT_W'(kin_r);
  assign b2     = bkt_r - k_b;
  assign kgrp   = GRP_W'(kin_r >> 3);
  assign ne_pad = PADW'(ne_r);
  assign region_page = base_page + 36'(regions_r) * 36'(BUCKETS - 1);

  // Scan one group of eight buckets per cycle for the first non-empty one.
  always_comb begin
    win  = ne_pad[{grp_r, 3'b000} +: SCAN_W];
    mask = (grp_r == kgrp) ? (8'hFF << kin_r[2:0]) : 8'hFF;
    hit  = |(win & mask);
    pe   = 3'd0;
    for (int i = SCAN_W - 1; i >= 0; i--) begin
      if (win[i] && mask[i]) pe = 3'(i);
    end
    hit_idx = BKT_W'({grp_r, pe});
  end

  // Sequencer: next state and memory controls.
  always_comb begin
    st_nxt     = st_r;
    q_pop      = 1'b0;
    head_ra    = hit_idx;
    span_ra    = d_r;
    head_we    = 1'b0;
    head_wa    = bkt_r;
    head_wd    = link_q;
    link_we    = 1'b0;
    link_wa    = d_r;
    link_wd    = spare_head_r;
    fp_we      = 1'b0;
    fp_wa      = d_r;
    fp_wd      = fp_q + 36'(kin_r);
    ne_set     = 1'b0;
    ne_set_idx = b2;
    ne_clr     = 1'b0;
    ne_clr_idx = bkt_r;
    refill     = 1'b0;
    refill_d   = fresh_cnt_r[DSC_W-1:0];
    load_out   = 1'b0;
    unique case (st_r)
      B_IDLE: begin
        if (q_head.valid) begin
          q_pop  = 1'b1;
          st_nxt = q_head.bad ? B_DONE : B_SCAN;
        end
      end
      B_SCAN: begin
        if (hit) begin
          st_nxt = B_HEAD;
        end else if (grp_r == GRP_W'(NGRP - 1)) begin
          st_nxt = B_REFILL;
        end
      end
      B_REFILL: begin
        span_ra = spare_head_r;
        if (regions_r >= region_limit) begin
          st_nxt = B_DONE;
        end else if (spare_cnt_r == '0 && fresh_cnt_r >= CNT_W'(SPAN_ENTRIES)) begin
          st_nxt = B_DONE;
        end else if (spare_cnt_r != '0) begin
          st_nxt = B_SPARE;
        end else begin
          refill = 1'b1;
          st_nxt = B_SCAN;
        end
      end
      B_SPARE: begin
        refill   = 1'b1;
        refill_d = spare_head_r;
        st_nxt   = B_SCAN;
      end
      B_HEAD: begin
        span_ra = head_q;
        st_nxt  = B_SPAN;
      end
      B_SPAN: begin
        // Pop the head descriptor off its bucket.
        if (link_q == d_r) begin
          ne_clr = 1'b1;
        end else begin
          head_we = 1'b1;
        end
        head_ra = b2;
        if (bkt_r == k_b) begin
          link_we = 1'b1;
          st_nxt  = B_DONE;
        end else begin
          fp_we  = 1'b1;
          st_nxt = B_PUSH;
        end
      end
      B_PUSH: begin
        // Push the remainder onto the bucket for its new size.
        link_we = 1'b1;
        link_wd = ne_r[b2] ? head_q : d_r;
        head_we = 1'b1;
        head_wa = b2;
        head_wd = d_r;
        ne_set  = 1'b1;
        st_nxt  = B_DONE;
      end
      B_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          load_out = 1'b1;
          st_nxt   = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
    // A refill places a new region descriptor alone in the top bucket.
    if (refill) begin
      fp_we      = 1'b1;
      fp_wa      = refill_d;
      fp_wd      = region_page;
      link_we    = 1'b1;
      link_wa    = refill_d;
      link_wd    = refill_d;
      head_we    = 1'b1;
      head_wa    = BKT_W'(BUCKETS - 1);
      head_wd    = refill_d;
      ne_set     = 1'b1;
      ne_set_idx = BKT_W'(BUCKETS - 1);
    end
  end

  // Memory ports.
  always_ff @(posedge clk) begin
    head_q <= head_mem[head_ra];
    if (head_we) head_mem[head_wa] <= head_wd;
  end

  always_ff @(posedge clk) begin
    fp_q   <= fp_mem[span_ra];
    link_q <= link_mem[span_ra];
    if (fp_we) fp_mem[fp_wa] <= fp_wd;
    if (link_we) link_mem[link_wa] <= link_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Control state and bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ne_r        <= '0;
      spare_cnt_r <= '0;
      fresh_cnt_r <= '0;
      regions_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ne_clr) ne_r[ne_clr_idx] <= 1'b0;
      if (ne_set) ne_r[ne_set_idx] <= 1'b1;
      if (refill) regions_r <= regions_r + 1'b1;
      if (st_r == B_REFILL && refill) fresh_cnt_r <= fresh_cnt_r + 1'b1;
      if (st_r == B_SPARE) spare_cnt_r <= spare_cnt_r - 1'b1;
      if (st_r == B_SPAN && bkt_r == k_b) spare_cnt_r <= spare_cnt_r + 1'b1;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    unique case (st_r)
      B_IDLE: begin
        kin_r    <= q_head.k;
        grp_r    <= GRP_W'(q_head.k >> 3);
        start_r  <= '0;
        status_r <= ST_BADSIZE;
      end
      B_SCAN: begin
        bkt_r <= hit_idx;
        if (!hit) grp_r <= grp_r + 1'b1;
      end
      B_REFILL: begin
        grp_r <= kgrp;
        if (regions_r >= region_limit) begin
          status_r <= ST_EXHAUST;
        end else begin
          status_r <= ST_FULL;
        end
      end
      B_SPARE: begin
        grp_r        <= kgrp;
        spare_head_r <= link_q;
      end
      B_HEAD: d_r <= head_q;
      B_SPAN: begin
        start_r  <= fp_q;
        status_r <= ST_GRANT;
        if (bkt_r == k_b) spare_head_r <= d_r;
      end
      default: begin
      end
    endcase
    if (load_out) begin
      out_start_r  <= (status_r == ST_GRANT) ? start_r : '0;
      out_pages_r  <= (status_r == ST_GRANT) ? kin_r : '0;
      out_status_r <= status_r;
    end
  end

  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.span_start_page = out_start_r;
  assign out_rsp.span_pages      = out_pages_r;
  assign out_rsp.status          = out_status_r;

endmodule

>>> rtl/segregated_span_page_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segregated_span_page_allocator_core
// Span page allocator with per-size LIFO free lists and a region bump pointer.
// ----------------------------------------------------------------------------
// A request for k pages is queued by the front end and executed by a
// sequencer in the back end, one request at a time. The sequencer scans the
// bucket occupancy bits eight buckets per cycle, then reads the bucket head
// and descriptor memories through registered read ports. A request served
// from a bucket goes through the scan, then the pop, split and push; a
// refill adds a second scan. The front queue holds two requests and the
// output register holds one response, so input and output stall
// independently. No memory clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module segregated_span_page_allocator_core import ssa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  ssa_req_if.sink              in_req,
  ssa_resp_if.source           out_rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [PAGE_W-1:0]    cfg_data
);

  logic [PAGE_W-1:0]  base_page_r;
  logic [LIMIT_W-1:0] region_limit_r;
  qitem_t             q_head;
  logic               q_pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_page_r    <= '0;
      region_limit_r <= '1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_BASE_PAGE:    base_page_r    <= cfg_data;
        CFG_REGION_LIMIT: region_limit_r <= cfg_data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ssa_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  ssa_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .base_page    (base_page_r),
    .region_limit (region_limit_r),
    .out_rsp      (out_rsp)
  );

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the segregated span page allocator core. A local
// span-list model predicts every response, and the checker compares each
// response with the oldest prediction while both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import ssa_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [PAGE_W-1:0] PAGE_MAX = {PAGE_W{1'b1}};

  typedef struct packed {
    logic [PAGE_W-1:0] start;
    logic [K_W-1:0]    pages;
    status_t           status;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_BASE_PAGE;
  logic [PAGE_W-1:0] cfg_data = '0;

  ssa_req_if  req_ch ();
  ssa_resp_if rsp_ch ();

  segregated_span_page_allocator_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (req_ch.sink),
    .out_rsp  (rsp_ch.source),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // Allocator model state.
  logic [PAGE_W-1:0]  m_base;
  logic [LIMIT_W-1:0] m_limit;
  bit                 m_nonempty [BUCKETS];
  int                 m_head [BUCKETS];
  logic [PAGE_W-1:0]  m_first [SPAN_ENTRIES];
  int                 m_link [SPAN_ENTRIES];
  int                 m_spare_head;
  int                 m_spare_cnt;
  int                 m_fresh_cnt;
  int                 m_drawn;

  grant_t  pending_grants[$];
  status_t last_status;
  int      fail_count = 0;
  int      cycle_count = 0;
  int      rx_hold = 0;
  bit      idle_on = 1'b1;

  // Clock and run limit.
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Free-list operations of the model.
  task automatic list_push(input int b, input int d);
    m_link[d] = m_nonempty[b] ? m_head[b] : d;
    m_head[b] = d;
    m_nonempty[b] = 1'b1;
  endtask

  task automatic list_pop(input int b, output int d);
    int nx;
    d = m_head[b];
    nx = m_link[d];
    if (nx == d) m_nonempty[b] = 1'b0;
    else m_head[b] = nx;
  endtask

  task automatic carve_span(input int k, output bit ok, output logic [PAGE_W-1:0] start);
    int d;
    ok = 1'b0;
    start = '0;
    for (int i = k; i < BUCKETS; i++) begin
      if (m_nonempty[i]) begin
        list_pop(i, d);
        start = m_first[d];
        if (i == k) begin
          m_link[d] = m_spare_head;
          m_spare_head = d;
          m_spare_cnt++;
        end else begin
          m_first[d] = m_first[d] + PAGE_W'(k);
          list_push(i - k, d);
        end
        ok = 1'b1;
        break;
      end
    end
  endtask

  task automatic predict_grant(input logic [K_W-1:0] k, output grant_t g);
    bit ok;
    int d;
    g = '{start: '0, pages: '0, status: ST_GRANT};
    if (k == 0 || int'(k) >= BUCKETS) begin
      g.status = ST_BADSIZE;
    end else begin
      carve_span(k, ok, g.start);
      if (ok) begin
        g.pages = k;
      end else if (m_drawn >= int'(m_limit)) begin
        g.status = ST_EXHAUST;
      end else if (m_spare_cnt == 0 && m_fresh_cnt >= SPAN_ENTRIES) begin
        g.status = ST_FULL;
      end else begin
        if (m_spare_cnt > 0) begin
          d = m_spare_head;
          m_spare_head = m_link[d];
          m_spare_cnt--;
        end else begin
          d = m_fresh_cnt;
          m_fresh_cnt++;
        end
        m_first[d] = m_base + PAGE_W'(m_drawn) * PAGE_W'(BUCKETS - 1);
        m_drawn++;
        list_push(BUCKETS - 1, d);
        carve_span(k, ok, g.start);
        g.pages = k;
      end
    end
  endtask

  // Offer one request; the model is updated when the transaction completes.
  task automatic send_request(input logic [K_W-1:0] k);
    int gap;
    grant_t g;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.pages_requested <= k;
    do @(posedge clk); while (!req_ch.ready);
    predict_grant(k, g);
    last_status = g.status;
    pending_grants.push_back(g);
  endtask

  // Stop offering and wait for every outstanding response.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAGE_W-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BASE_PAGE) m_base = val;
    else m_limit = val[LIMIT_W-1:0];
  endtask

  // Response side: random stalls, then compare with the oldest prediction.
  initial begin : response_checker
    int gap;
    grant_t g;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = idle_on ? $urandom_range(0, 15) : 0;
      if (rx_hold > 0) begin
        gap = rx_hold;
        rx_hold = 0;
      end
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      if (pending_grants.size() == 0) begin
        $error("response with no request outstanding");
        fail_count++;
      end else begin
        g = pending_grants.pop_front();
        if (rsp_ch.span_start_page !== g.start) begin
          $error("span_start_page expected %0h actual %0h", g.start, rsp_ch.span_start_page);
          fail_count++;
        end
        if (rsp_ch.span_pages !== g.pages) begin
          $error("span_pages expected %0d actual %0d", g.pages, rsp_ch.span_pages);
          fail_count++;
        end
        if (rsp_ch.status !== g.status) begin
          $error("status expected %0d actual %0d", g.status, rsp_ch.status);
          fail_count++;
        end
      end
    end
  end

  // Field extremes, bad sizes, exact fits, splits and the first refills.
  task automatic test_directed();
    logic [K_W-1:0] sizes[] = '{7'd0, 7'd127, 7'd1, 7'd126, 7'd1, 7'd125, 7'd2,
                                7'd3, 7'd3, 7'd64, 7'd63, 7'd85, 7'd42, 7'd0,
                                7'd126, 7'd100};
    foreach (sizes[i]) send_request(sizes[i]);
    drain();
  endtask

  // Page numbers wrap past the top of the page space.
  task automatic test_base_wrap();
    write_reg(CFG_BASE_PAGE, PAGE_MAX - 36'd200);
    repeat (8) send_request(7'd120);
    send_request(7'd126);
    write_reg(CFG_BASE_PAGE, PAGE_MAX);
    repeat (4) send_request(7'd126);
  endtask

  // No further region may be drawn; buckets still serve what they hold.
  task automatic test_exhausted();
    write_reg(CFG_REGION_LIMIT, PAGE_W'(0));
    repeat (12) send_request(7'($urandom_range(1, 127)));
    write_reg(CFG_REGION_LIMIT, PAGE_W'(LIMIT_W'(m_drawn + 1)));
    repeat (6) send_request(7'd126);
    write_reg(CFG_REGION_LIMIT, PAGE_W'(16'hFFFF));
  endtask

  // Mostly small requests with random content, a few of every size.
  task automatic test_random(input int count);
    logic [K_W-1:0] k;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: k = 7'($urandom);
        1, 2: k = 7'($urandom_range(17, 127));
        default: k = 7'($urandom_range(1, 16));
      endcase
      send_request(k);
    end
    idle_on = 1'b1;
  endtask

  // The receiver holds off while requests keep coming, then the sender pauses.
  task automatic test_backpressure();
    idle_on = 1'b0;
    rx_hold = 400;
    repeat (40) send_request(7'($urandom_range(1, 127)));
    idle_on = 1'b1;
    drain();
    repeat (20) send_request(7'($urandom_range(1, 30)));
  endtask

  // Each 64-page request leaves a 63-page remainder and needs a new descriptor.
  task automatic test_store_full();
    int n = 0;
    idle_on = 1'b0;
    last_status = ST_GRANT;
    while (last_status != ST_FULL && n < 1600) begin
      send_request(7'd64);
      n++;
    end
    repeat (3) send_request(7'd100);
    repeat (3) send_request(7'd63);
    idle_on = 1'b1;
    drain();
  endtask

  initial begin : main
    req_ch.valid <= 1'b0;
    req_ch.pages_requested <= '0;
    m_base = '0;
    m_limit = 16'hFFFF;
    foreach (m_nonempty[i]) m_nonempty[i] = 1'b0;
    m_spare_head = 0;
    m_spare_cnt = 0;
    m_fresh_cnt = 0;
    m_drawn = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_base_wrap();
    test_exhausted();
    write_reg(CFG_BASE_PAGE, PAGE_W'({$urandom, $urandom}));
    test_random(120);
    test_backpressure();
    write_reg(CFG_BASE_PAGE, 36'd0);
    write_reg(CFG_REGION_LIMIT, PAGE_W'(LIMIT_W'(m_drawn + $urandom_range(0, 3))));
    test_random(80);
    write_reg(CFG_REGION_LIMIT, PAGE_W'(16'hFFFF));
    write_reg(CFG_BASE_PAGE, PAGE_W'({$urandom, $urandom}));
    test_random(150);
    drain();
    test_store_full();

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ssa_pkg.sv
rtl/ssa_if.sv
rtl/ssa_front.sv
rtl/ssa_back.sv
rtl/segregated_span_page_allocator_core.sv
tb/sv/testbench.sv
